### hdl/lte_pkg.sv
// Shared constants, codes and helpers of the letter trie engine.
`timescale 1ns / 1ps
package lte_pkg;
  localparam int NodesDefault     = 1024;
  localparam int ValueBitsDefault = 32;
  localparam int Letters          = 26;
  localparam int CountW           = 11;
  localparam logic [CountW-1:0] CountMax = 11'd2047;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_SEARCH = 3'd1;
  localparam logic [2:0] MODE_PREFIX = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic       hit;
    logic [4:0] slot;
  } letter_t;

  function automatic letter_t letter_of(input logic [7:0] ch);
    letter_t r;
    r.hit  = 1'b0;
    r.slot = 5'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r.hit  = 1'b1;
      r.slot = 5'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r.hit  = 1'b1;
      r.slot = 5'(ch - 8'h61);
    end
    return r;
  endfunction
endpackage

### hdl/lte_core.sv
// Trie walk sequencer with the child, end mark and value memories.
`timescale 1ns / 1ps
module lte_core import lte_pkg::*; #(
  parameter int NODES      = NodesDefault,
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_mode,
  input  logic [7:0]        in_key_char,
  input  logic              in_last,
  input  logic [31:0]       in_value,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [1:0]        res_status,
  output logic [31:0]       res_found,
  output logic [CountW-1:0] res_total
);
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AW = $clog2(NODES * Letters);
  localparam int FW = NW + 1;
  localparam logic [FW-1:0] NodesF = FW'(NODES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_CLR   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [NW-1:0]         child_mem [NODES*Letters];
  logic                  end_mem   [NODES];
  logic [VALUE_BITS-1:0] val_mem   [NODES];
  logic                  root_valid_r [Letters];

  logic [2:0]        state_r, state_nxt;
  logic              in_key_r, in_key_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [NW-1:0]     node_r, node_nxt;
  logic [1:0]        fail_r, fail_nxt;
  logic [FW-1:0]     free_r, free_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [4:0]        slot_r, slot_nxt;
  logic              last_r, last_nxt;
  logic [31:0]       value_r, value_nxt;
  logic [4:0]        zc_r, zc_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [31:0]       fv_r, fv_nxt;

  logic [NW-1:0]         child_q;
  logic                  end_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  root_rd_r;
  logic [4:0]            root_slot_r;
  logic                  root_end_r;
  logic                  rd_root_r;
  logic                  end_v;

  logic              cw_en, ew_en, vw_en;
  logic [AW-1:0]     cw_addr, cr_addr;
  logic [NW-1:0]     cw_data;
  logic [NW-1:0]     ew_addr, er_addr;
  logic              ew_data;
  logic [VALUE_BITS-1:0] vw_data;
  logic              root_clr;
  logic              root_set;

  letter_t  lt;
  logic [2:0] emode;
  logic [NW-1:0] child_v;

  assign lt    = letter_of(in_key_char);
  assign emode = in_key_r ? mode_r : in_mode;
  assign in_tready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_status = st_r;
  assign res_found  = fv_r;
  assign res_total  = count_r;
  assign child_v = (root_rd_r && !root_valid_r[root_slot_r]) ? '0 : child_q;
  assign end_v   = rd_root_r ? root_end_r : end_q;

  always_ff @(posedge clk) begin
    if (cw_en) child_mem[cw_addr] <= cw_data;
    child_q <= child_mem[cr_addr];
    if (ew_en) end_mem[ew_addr] <= ew_data;
    end_q <= end_mem[er_addr];
    if (vw_en) val_mem[ew_addr] <= vw_data;
    val_q <= val_mem[er_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Letters; i++) root_valid_r[i] <= 1'b0;
    end else if (root_clr) begin
      for (int i = 0; i < Letters; i++) root_valid_r[i] <= 1'b0;
    end else if (root_set) begin
      root_valid_r[slot_r] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;  in_key_nxt = in_key_r; mode_nxt = mode_r;
    node_nxt = node_r;    fail_nxt = fail_r;     free_nxt = free_r;
    count_nxt = count_r;  slot_nxt = slot_r;     last_nxt = last_r;
    value_nxt = value_r;  zc_nxt = zc_r;         st_nxt = st_r; fv_nxt = fv_r;
    cw_en = 1'b0; ew_en = 1'b0; vw_en = 1'b0;
    cw_addr = '0; cw_data = '0; ew_addr = node_r; ew_data = 1'b0; vw_data = '0;
    cr_addr = AW'(node_r * Letters + slot_r);
    er_addr = node_r;
    root_clr = 1'b0; root_set = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          in_key_nxt = 1'b1;
          mode_nxt   = emode;
          last_nxt   = in_last;
          value_nxt  = in_value;
          slot_nxt   = lt.slot;
          if (!in_key_r) begin
            node_nxt = '0;
            fail_nxt = 2'd0;
          end
          if (lt.hit && (in_key_r ? fail_r == 2'd0 : 1'b1) && emode <= MODE_DELETE) begin
            cr_addr   = AW'((in_key_r ? node_r : '0) * Letters + lt.slot);
            state_nxt = S_READ;
          end else if (in_last) begin
            state_nxt = (emode == MODE_CLEAR) ? S_CLR : S_FIN;
          end
        end
      end
      S_READ: begin
        if (child_v != '0) begin
          node_nxt  = child_v;
          er_addr   = child_v;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (mode_r != MODE_INSERT) begin
          fail_nxt  = 2'd1;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (free_r >= NodesF) begin
          fail_nxt  = 2'd2;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else begin
          cw_en   = 1'b1;
          cw_addr = AW'(node_r * Letters + slot_r);
          cw_data = NW'(free_r);
          root_set = (node_r == '0);
          ew_en   = 1'b1;
          vw_en   = 1'b1;
          ew_addr = NW'(free_r);
          node_nxt = NW'(free_r);
          free_nxt = free_r + 1'b1;
          zc_nxt   = '0;
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        cw_en   = 1'b1;
        cw_addr = AW'(node_r * Letters + zc_r);
        zc_nxt  = zc_r + 1'b1;
        if (zc_r == 5'(Letters - 1)) state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        st_nxt = ST_OK; fv_nxt = '0;
        case (mode_r)
          MODE_INSERT: begin
            if (fail_r != 2'd0) st_nxt = fail_r;
            else begin
              ew_en = 1'b1; vw_en = 1'b1; ew_data = 1'b1;
              vw_data = VALUE_BITS'($signed(value_r));
              if (!end_v && count_r < CountMax) count_nxt = count_r + 1'b1;
            end
          end
          MODE_SEARCH: begin
            if (fail_r != 2'd0 || !end_v) st_nxt = ST_MISSING;
            else fv_nxt = 32'($signed(val_q));
          end
          MODE_PREFIX: st_nxt = (fail_r != 2'd0) ? ST_MISSING : ST_OK;
          MODE_DELETE: begin
            if (fail_r != 2'd0 || !end_v) st_nxt = ST_MISSING;
            else begin
              ew_en = 1'b1;
              if (count_r != '0) count_nxt = count_r - 1'b1;
            end
          end
          default: st_nxt = ST_MISSING;
        endcase
        in_key_nxt = 1'b0;
        state_nxt  = S_OUT;
      end
      S_CLR: begin
        root_clr = 1'b1;
        free_nxt = FW'(1);
        count_nxt = '0;
        st_nxt = ST_OK; fv_nxt = '0;
        in_key_nxt = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        node_nxt = '0;
        fail_nxt = 2'd0;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    root_rd_r   <= (node_nxt == '0) && (state_nxt == S_READ);
    root_slot_r <= slot_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE; in_key_r <= 1'b0; mode_r <= MODE_INSERT;
      node_r <= '0; fail_r <= 2'd0; free_r <= FW'(1); count_r <= '0;
    end else begin
      state_r <= state_nxt; in_key_r <= in_key_nxt; mode_r <= mode_nxt;
      node_r <= node_nxt; fail_r <= fail_nxt; free_r <= free_nxt; count_r <= count_nxt;
    end
    slot_r <= slot_nxt; last_r <= last_nxt; value_r <= value_nxt;
    zc_r <= zc_nxt; st_r <= st_nxt; fv_r <= fv_nxt;
  end

  // root end mark lives in its own flop so it needs no clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) root_end_r <= 1'b0;
    else if (ew_en && ew_addr == '0) root_end_r <= ew_data;
  end
  always_ff @(posedge clk) rd_root_r <= (er_addr == '0);

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r >= FW'(1) && free_r <= NodesF) else $error("free pointer out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_status))
    else $error("result dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid) else $error("ready while result pending");
endmodule

### hdl/letter_trie_engine.sv
// Top level of the letter trie engine.
`timescale 1ns / 1ps
// Letter trie over a pool of NODES nodes held in a child memory of NODES*26 entries.
// Each letter byte of a walk (insert, search, prefix, delete) that has not failed takes a
// child-memory read, then the step; other bytes are taken in the idle state alone. A new
// node adds a pass that zeroes its children; the last byte adds a finish and a result state.
// One word is handled at a time; a clear takes the finish state's place, with no sweep.
module letter_trie_engine import lte_pkg::*; #(
  parameter int NODES      = NodesDefault,
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // mode[2:0], key_char[10:3], entry_value[42:11]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata  // status[1:0], found_value[33:2], key_total[44:34]
);
  logic [1:0]        st;
  logic [31:0]       fv;
  logic [CountW-1:0] kt;

  lte_core #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_core (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_mode(in_tdata[2:0]), .in_key_char(in_tdata[10:3]),
    .in_last(in_tlast), .in_value(in_tdata[42:11]),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_status(st), .res_found(fv), .res_total(kt)
  );

  assign out_tdata = {3'b000, kt, fv, st};
endmodule

### tb/letter_trie_engine_tb.sv
// Self-checking bench for the letter trie engine: directed table, then random key traffic.
`timescale 1ns / 1ps
module letter_trie_engine_tb;
  import lte_pkg::*;

  localparam int NodeCount = 1024;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found;
    logic [10:0] total;
  } trie_answer_t;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  ch;
    logic        last;
    logic [31:0] value;
    logic        known;
    logic [1:0]  status;
    logic [31:0] found;
    logic [10:0] total;
  } trie_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  letter_trie_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // trie shadow
  logic [9:0]  kids [NodeCount*Letters];
  logic        marked [NodeCount];
  logic [31:0] stored [NodeCount];
  int unsigned free_node, key_tally, cur_node, miss_code;
  logic [2:0]  cur_mode;
  logic        mid_key;

  trie_answer_t answers_due[$];
  int errors = 0;
  int words_sent = 0, answers_seen = 0, full_seen = 0, found_seen = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  logic calm = 1'b0;
  logic [31:0] keyval;

  function automatic trie_answer_t trie_apply(input logic [2:0] md, input logic [7:0] ch,
                                              input logic last, input logic [31:0] val);
    trie_answer_t a;
    letter_t l;
    int unsigned pos, nxt;
    a = '0;
    if (!mid_key) begin
      cur_mode = md; cur_node = 0; miss_code = 0; mid_key = 1'b1;
    end
    l = letter_of(ch);
    if (l.hit && miss_code == 0 && cur_mode <= MODE_DELETE) begin
      pos = cur_node * Letters + l.slot;
      nxt = kids[pos];
      if (nxt == 0) begin
        if (cur_mode != MODE_INSERT) miss_code = 1;
        else if (free_node >= NodeCount) miss_code = 2;
        else begin
          nxt = free_node++;
          for (int i = 0; i < Letters; i++) kids[nxt*Letters+i] = '0;
          marked[nxt] = 1'b0;
          stored[nxt] = '0;
          kids[pos] = nxt[9:0];
        end
      end
      if (miss_code == 0) cur_node = nxt;
    end
    if (!last) return a;
    case (cur_mode)
      MODE_INSERT: begin
        if (miss_code != 0) a.status = miss_code[1:0];
        else begin
          if (!marked[cur_node]) begin
            marked[cur_node] = 1'b1;
            if (key_tally < CountMax) key_tally++;
          end
          stored[cur_node] = val;
        end
      end
      MODE_SEARCH: begin
        if (miss_code != 0 || !marked[cur_node]) a.status = ST_MISSING;
        else a.found = stored[cur_node];
      end
      MODE_PREFIX: a.status = (miss_code != 0) ? ST_MISSING : ST_OK;
      MODE_DELETE: begin
        if (miss_code != 0 || !marked[cur_node]) a.status = ST_MISSING;
        else begin
          marked[cur_node] = 1'b0;
          if (key_tally > 0) key_tally--;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < Letters; i++) kids[i] = '0;
        free_node = 1;
        key_tally = 0;
      end
      default: a.status = ST_MISSING;
    endcase
    a.total = key_tally[10:0];
    mid_key = 1'b0;
    cur_node = 0;
    miss_code = 0;
    return a;
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    trie_answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[33:2], out_tdata[44:34]};
      answers_seen++;
      if (answers_due.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
        if (got.found != want.found) begin
          $error("found_value: expected %h, got %h", want.found, got.found); errors++;
        end
        if (got.total != want.total) begin
          $error("key_total: expected %0d, got %0d", want.total, got.total); errors++;
        end
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_OK && want.found != 0) found_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("letter_trie_engine_tb: FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [2:0] md, input logic [7:0] ch, input logic last,
                           input logic [31:0] val, input logic known,
                           input trie_answer_t fixed);
    trie_answer_t a;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, val, ch, md};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    a = trie_apply(md, ch, last, val);
    if (last) begin
      if (known && a != fixed) begin
        $error("table row disagrees with shadow: %h vs %h", fixed, a);
        errors++;
      end
      answers_due.push_back(a);
    end
    words_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter(input int span);
    logic [7:0] c;
    c = 8'h41 + 8'($urandom_range(0, span - 1));
    if ($urandom_range(0, 1)) c = c + 8'h20;
    return c;
  endfunction

  task automatic send_key(input logic [2:0] md, input int span, input int len);
    keyval = $urandom;
    for (int i = 0; i < len; i++) begin
      logic [7:0] c;
      c = ($urandom_range(0, 15) == 0) ? 8'($urandom) : rand_letter(span);
      send_word(md, c, i == len - 1, keyval, 1'b0, '0);
    end
  endtask

  trie_row_t plan[$];

  task automatic add_row(input logic [2:0] md, input logic [7:0] ch, input logic last,
                         input logic [31:0] val, input logic known, input logic [1:0] st,
                         input logic [31:0] fv, input logic [10:0] tot);
    trie_row_t r;
    r.mode = md; r.ch = ch; r.last = last; r.value = val; r.known = known;
    r.status = st; r.found = fv; r.total = tot;
    plan.push_back(r);
  endtask

  initial begin
    trie_answer_t fx;
    for (int i = 0; i < NodeCount*Letters; i++) kids[i] = '0;
    for (int i = 0; i < NodeCount; i++) begin
      marked[i] = 1'b0; stored[i] = '0;
    end
    free_node = 1; key_tally = 0; cur_node = 0; miss_code = 0; cur_mode = '0; mid_key = 1'b0;

    add_row(MODE_SEARCH, 8'h41, 1, 0, 1, ST_MISSING, 0, 0);
    add_row(MODE_DELETE, 8'h7A, 1, 0, 1, ST_MISSING, 0, 0);
    add_row(MODE_INSERT, 8'h41, 0, 0, 0, 0, 0, 0);
    add_row(MODE_INSERT, 8'h5A, 1, 32'h7FFFFFFF, 1, ST_OK, 0, 1);
    add_row(MODE_SEARCH, 8'h61, 0, 0, 0, 0, 0, 0);
    add_row(MODE_SEARCH, 8'h7A, 1, 0, 1, ST_OK, 32'h7FFFFFFF, 1);
    add_row(MODE_INSERT, 8'h00, 1, 32'h80000000, 1, ST_OK, 0, 2);
    add_row(MODE_SEARCH, 8'hFF, 1, 0, 1, ST_OK, 32'h80000000, 2);
    add_row(MODE_PREFIX, 8'h41, 1, 0, 1, ST_OK, 0, 2);
    add_row(MODE_PREFIX, 8'h40, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PREFIX, 8'h5B, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PREFIX, 8'h60, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PREFIX, 8'h7B, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PREFIX, 8'h62, 1, 0, 1, ST_MISSING, 0, 2);
    add_row(MODE_SEARCH, 8'h41, 1, 0, 1, ST_MISSING, 0, 2);
    add_row(3'd5, 8'h41, 1, 0, 1, ST_MISSING, 0, 2);
    add_row(3'd7, 8'h80, 1, 0, 1, ST_MISSING, 0, 2);
    add_row(MODE_DELETE, 8'h41, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DELETE, 8'h5A, 1, 0, 1, ST_OK, 0, 1);
    add_row(MODE_CLEAR, 8'h41, 0, 0, 0, 0, 0, 0);
    add_row(MODE_CLEAR, 8'h00, 1, 0, 1, ST_OK, 0, 0);
    add_row(MODE_SEARCH, 8'h20, 1, 0, 1, ST_OK, 32'h80000000, 0);
    add_row(MODE_DELETE, 8'h2E, 1, 0, 1, ST_OK, 0, 0);
    add_row(MODE_DELETE, 8'h2E, 1, 0, 1, ST_MISSING, 0, 0);

    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      fx.status = plan[i].status; fx.found = plan[i].found; fx.total = plan[i].total;
      send_word(plan[i].mode, plan[i].ch, plan[i].last, plan[i].value, plan[i].known, fx);
    end
    drain();

    // fill the pool with long inserts until exhaustion answers
    while (full_seen < 3) send_key(MODE_INSERT, 26, $urandom_range(8, 14));
    send_word(MODE_CLEAR, 8'h00, 1, 0, 0, '0);

    while (words_sent < 1600) begin
      int pick;
      if (words_sent > 1350) calm = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 8) send_key(MODE_INSERT, 4, $urandom_range(1, 4));
      else if (pick < 12) send_key(MODE_SEARCH, 4, $urandom_range(1, 4));
      else if (pick < 14) send_key(MODE_PREFIX, 4, $urandom_range(1, 3));
      else if (pick < 17) send_key(MODE_DELETE, 4, $urandom_range(1, 4));
      else if (pick == 17) send_key(3'($urandom_range(5, 7)), 26, $urandom_range(1, 3));
      else if (pick == 18) send_key(3'($urandom), 26, $urandom_range(1, 3));
      else if ($urandom_range(0, 9) == 0) send_word(MODE_CLEAR, 8'($urandom), 1, 0, 0, '0);
      else drain();
    end
    drain();
    repeat (200) @(posedge clk);

    $display("sent %0d words, checked %0d results (%0d pool-full, %0d search hits)",
             words_sent, answers_seen, full_seen, found_seen);
    if (errors == 0 && answers_due.size() == 0) $display("letter_trie_engine_tb: PASS");
    else $display("letter_trie_engine_tb: FAIL");
    $finish;
  end
endmodule
